// ===== src/iis_pkg.sv =====
// ============================================================================
// iis_pkg
// Shared types and constants for the incremental insertion sorter.
// ============================================================================
`default_nettype none

package iis_pkg;

    // Default number of entries in the sorted store
    localparam int unsigned STORE_DEPTH_DEF = 32;

    // Input item
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               end_of_set;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_value;
        logic               overflowed;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic insert;      // insert the input value (or drop it when full)
        logic pop;         // shift the store down by one after an output transfer
        logic clear_drop;  // clear the overflow flag at the end of a run
    } iis_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_one;    // exactly one stored value remains
    } iis_status_t;

endpackage : iis_pkg

`default_nettype wire

// ===== src/iis_datapath.sv =====
// ============================================================================
// iis_datapath
// Register array kept in ascending order: parallel compare-and-shift insert,
// shift-down readout from entry zero, fill count and overflow flag.
// ============================================================================
`default_nettype none

module iis_datapath #(
    parameter int unsigned STORE_DEPTH = iis_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire iis_pkg::iis_cmd_t      cmd,
    input  wire logic signed [31:0]     in_value,
    output iis_pkg::iis_status_t        status,
    output iis_pkg::out_item_t          out_item
);
    import iis_pkg::*;

    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

    logic signed [31:0]     store_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] greater;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic                   full;

    assign full = (count_reg == CW'(STORE_DEPTH));

    // Flag every valid entry that is strictly greater than the new value
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            greater[i] = (CW'(i) < count_reg) && (store_reg[i] > in_value);
        end
    end

    // One cell per entry: keep, take the new value, take the lower neighbor,
    // or take the upper neighbor while draining
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        logic signed [31:0] below;
        logic               below_gt;
        logic signed [31:0] above;
        logic signed [31:0] cell_next;

        if (g == 0) begin : g_first
            assign below    = in_value;
            assign below_gt = 1'b0;
        end else begin : g_rest
            assign below    = store_reg[g-1];
            assign below_gt = greater[g-1];
        end

        if (g == STORE_DEPTH - 1) begin : g_top
            assign above = store_reg[g];
        end else begin : g_inner
            assign above = store_reg[g+1];
        end

        always_comb begin
            cell_next = store_reg[g];
            if (cmd.insert && !full && (greater[g] || (CW'(g) == count_reg))) begin
                cell_next = below_gt ? below : in_value;
            end else if (cmd.pop) begin
                cell_next = above;
            end
        end

        always_ff @(posedge aclk) begin
            store_reg[g] <= cell_next;
        end
    end

    // Fill count and overflow flag
    always_comb begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (cmd.insert) begin
            if (full) begin
                drop_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.clear_drop) begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    // Smallest stored value is always in entry zero
    assign status.last_one       = (count_reg == CW'(1));
    assign out_item.sorted_value = store_reg[0];
    assign out_item.final_value  = (count_reg == CW'(1));
    assign out_item.overflowed   = drop_reg;

endmodule : iis_datapath

`default_nettype wire

// ===== src/iis_ctrl.sv =====
// ============================================================================
// iis_ctrl
// Controller: collect values until the end mark, then drain the store.
// ============================================================================
`default_nettype none

module iis_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_end_of_set,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire iis_pkg::iis_status_t   status,
    output iis_pkg::iis_cmd_t           cmd
);
    import iis_pkg::*;

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready = (state_reg == ST_COLLECT);
    assign m_valid = (state_reg == ST_DRAIN);

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        cmd.insert     = 1'b0;
        cmd.pop        = 1'b0;
        cmd.clear_drop = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                if (s_valid) begin
                    cmd.insert = 1'b1;
                    if (s_end_of_set) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_ready) begin
                    cmd.pop = 1'b1;
                    if (status.last_one) begin
                        cmd.clear_drop = 1'b1;
                        state_next     = ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : iis_ctrl

`default_nettype wire

// ===== src/incremental_insertion_sorter.sv =====
// ============================================================================
// incremental_insertion_sorter
// Keeps incoming signed values in ascending order and drains them on the
// end-of-set mark.
//
//   Channel | Ports                      | Direction | Payload
//   --------+----------------------------+-----------+---------------------
//   input   | s_valid, s_ready, s_data   | in        | sample_value, end_of_set
//   result  | m_valid, m_ready, m_data   | out       | sorted_value, final_value,
//           |                            |           | overflowed
//
// Each input value is inserted by the parallel compare-and-shift register array,
// so values stream in at one per cycle while the sorter is collecting.
// After the end mark, the run drains from entry zero at one result per cycle
// while m_ready is high; the input is held off (s_ready low) until the final
// result transfers. Values dropped on a full store are still accepted.
// Reset (aresetn low, synchronous) empties the store and clears the overflow
// flag; stalls on m_ready simply hold the current result.
// ============================================================================
`default_nettype none

module incremental_insertion_sorter #(
    parameter int unsigned STORE_DEPTH = iis_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire iis_pkg::in_item_t      s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output iis_pkg::out_item_t          m_data
);
    import iis_pkg::*;

    iis_cmd_t    cmd;
    iis_status_t status;

    iis_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_end_of_set (s_data.end_of_set),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .status       (status),
        .cmd          (cmd)
    );

    iis_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_value (s_data.sample_value),
        .status   (status),
        .out_item (m_data)
    );

`ifndef ASSERT_OFF
    // Never collect and drain at the same time
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    // An end mark starts the drain in the next cycle
    a_end_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_set) |=> m_valid)
        else $error("end of set did not start output");

    // The final result reopens the input
    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_value) |=> (s_ready && !m_valid))
        else $error("input not reopened after final result");
`endif

endmodule : incremental_insertion_sorter

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: incremental insertion sorter testbench
// Streams sets of signed values into the sorter and checks that each end-marked
// set comes back in ascending order, with the final and overflow flags set right.
// A directed table runs first. Random sets of mixed length follow, some of them
// overfilling the store. Both channels idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import iis_pkg::*;

    localparam int unsigned DEPTH      = STORE_DEPTH_DEF;
    localparam int unsigned ITEM_BUDGET = 410;
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 20;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One row of the directed table; typed rows carry their single result
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } stim_row_t;

    localparam int unsigned DIR_ROWS = 23;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Sorted-set predictor and the results it expects
    logic signed [31:0] sorted_model[$];
    bit                 dropped_in_set;
    out_item_t          expected_results[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned items_sent;
    bit          long_hold_req;
    bit          long_hold_done;

    stim_row_t directed_rows [DIR_ROWS] = '{
        // single-value sets: the value comes straight back as the final one
        '{'{VAL_MIN, 1'b1},     1'b1, '{VAL_MIN, 1'b1, 1'b0}},
        '{'{VAL_MAX, 1'b1},     1'b1, '{VAL_MAX, 1'b1, 1'b0}},
        '{'{32'sd0, 1'b1},      1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{-32'sd1, 1'b1},     1'b1, '{-32'sd1, 1'b1, 1'b0}},
        '{'{32'sd1, 1'b1},      1'b1, '{32'sd1, 1'b1, 1'b0}},
        // descending arrival
        '{'{VAL_MAX, 1'b0},     1'b0, '0},
        '{'{32'sd1000, 1'b0},   1'b0, '0},
        '{'{32'sd0, 1'b0},      1'b0, '0},
        '{'{-32'sd1000, 1'b0},  1'b0, '0},
        '{'{VAL_MIN, 1'b1},     1'b0, '0},
        // ascending arrival
        '{'{VAL_MIN, 1'b0},     1'b0, '0},
        '{'{-32'sd1, 1'b0},     1'b0, '0},
        '{'{32'sd0, 1'b0},      1'b0, '0},
        '{'{32'sd1, 1'b0},      1'b0, '0},
        '{'{VAL_MAX, 1'b1},     1'b0, '0},
        // equal values
        '{'{32'sd7, 1'b0},      1'b0, '0},
        '{'{-32'sd7, 1'b0},     1'b0, '0},
        '{'{32'sd7, 1'b0},      1'b0, '0},
        '{'{32'sd7, 1'b0},      1'b0, '0},
        '{'{-32'sd7, 1'b1},     1'b0, '0},
        // alternating bit patterns
        '{'{32'sh5555_5555, 1'b0}, 1'b0, '0},
        '{'{32'shAAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{32'sh8000_0001, 1'b1}, 1'b0, '0}
    };

    incremental_insertion_sorter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Insert one accepted value (or note a drop when full); on the end mark, queue the whole set in order
    function automatic void absorb_sample(in_item_t item);
        int unsigned pos;
        out_item_t   res;
        if (sorted_model.size() >= DEPTH) begin
            dropped_in_set = 1'b1;
        end else begin
            pos = 0;
            while (pos < sorted_model.size() && sorted_model[pos] <= item.sample_value)
                pos++;
            sorted_model.insert(pos, item.sample_value);
        end
        if (item.end_of_set) begin
            for (int unsigned i = 0; i < sorted_model.size(); i++) begin
                res.sorted_value = sorted_model[i];
                res.final_value  = (i + 1 == sorted_model.size());
                res.overflowed   = dropped_in_set;
                expected_results.push_back(res);
            end
            sorted_model.delete();
            dropped_in_set = 1'b0;
        end
    endfunction

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $signed($urandom_range(0, 15)) - 32'sd8;
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one item in a burst pattern and hold it until the transfer
    task automatic send_item(input in_item_t item, input bit typed, input out_item_t typed_res);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
        if (typed)
            expected_results.push_back(typed_res);
        else
            absorb_sample(item);
    endtask

    task automatic send_set(input int unsigned len);
        in_item_t item;
        for (int unsigned i = 0; i < len; i++) begin
            item.sample_value = pick_value();
            item.end_of_set   = (i + 1 == len);
            send_item(item, 1'b0, '0);
        end
    endtask

    // Stimulus: reset, directed table, random sets, drain, verdict
    initial begin
        int unsigned set_no;
        int unsigned len;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        mismatch_count = 0;
        burst_left     = 0;
        items_sent     = 0;
        long_hold_req  = 1'b0;
        dropped_in_set = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int unsigned r = 0; r < DIR_ROWS; r++)
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);

        long_hold_req = 1'b1;
        set_no = 0;
        while (items_sent < ITEM_BUDGET) begin
            // lead with an overfilled set (end mark dropped too) and an exactly full one
            if (set_no == 0)
                len = DEPTH + 3;
            else if (set_no == 1)
                len = DEPTH;
            else begin
                case ($urandom_range(0, 19))
                    0:       len = DEPTH + $urandom_range(1, 4);
                    1:       len = DEPTH;
                    default: len = $urandom_range(1, 8);
                endcase
            end
            send_set(len);
            set_no++;
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stretches of differing stall patterns, one long hold-off
    initial begin
        int unsigned mode;
        int unsigned len;
        m_ready        <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            for (int unsigned k = 0; k < len; k++) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (k % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: unexpected result value=%0d final=%0b ovf=%0b",
                             m_data.sorted_value, m_data.final_value, m_data.overflowed);
            end else begin
                want = expected_results.pop_front();
                if (m_data.sorted_value !== want.sorted_value ||
                    m_data.final_value  !== want.final_value  ||
                    m_data.overflowed   !== want.overflowed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.sorted_value, want.final_value, want.overflowed,
                                 m_data.sorted_value, m_data.final_value,
                                 m_data.overflowed);
                end
            end
        end
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
